/* sv/recent_address_ttl_cache_top_assert.svh */
// Concurrent assertion helpers, clocked on clk_i and held off during reset.
`ifndef RECENT_ADDRESS_TTL_CACHE_TOP_ASSERT_SVH
`define RECENT_ADDRESS_TTL_CACHE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define RATTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define RATTC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define RATTC_ASSERT(lbl, prop, msg)
`define RATTC_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

/* sv/rattc_pkg.sv */
package rattc_pkg;

  localparam int unsigned ADDR_W = 24;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned TTL_W  = 16;
  localparam int unsigned HASH_W = 32;
  localparam int unsigned SLOT_W = ADDR_W + TIME_W;

  localparam int unsigned CACHE_ENTRIES_DEF = 1024;

  localparam logic [HASH_W-1:0] MIX_MULT  = 32'h045d_9f3b;
  localparam logic [TTL_W-1:0]  TTL_RESET = 16'd60;

  typedef enum logic {
    MODE_RECORD = 1'b0,
    MODE_LOOKUP = 1'b1
  } mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MIX1,
    ST_MIX2,
    ST_ACCESS,
    ST_READ,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
  } mix_ctrl_t;

endpackage

/* sv/rattc_ram.sv */
module rattc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/rattc_mix.sv */
module rattc_mix (
  input  logic                           clk_i,
  input  rattc_pkg::mix_ctrl_t           ctrl_i,
  input  logic [rattc_pkg::ADDR_W-1:0]   addr_i,
  output logic [rattc_pkg::HASH_W-1:0]   hash_o
);
  import rattc_pkg::*;

  logic [HASH_W-1:0] x_q, x_d;
  logic [HASH_W-1:0] folded;

  // xor-shift-16 fold, shared by each round and the final step
  assign folded = x_q ^ (x_q >> 16);

  always_comb begin
    x_d = x_q;
    if (ctrl_i.load) begin
      x_d = {{(HASH_W-ADDR_W){1'b0}}, addr_i};
    end else if (ctrl_i.step) begin
      x_d = folded * MIX_MULT;  // mod 2^32
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
  end

  assign hash_o = folded;

endmodule

/* sv/recent_address_ttl_cache_top.sv */
// Flow: a record word passes ST_MIX1, ST_MIX2, ST_ACCESS and ST_DONE; a lookup adds ST_READ
// before ST_DONE. The next word is taken the cycle after the result leaves; out_stall_i holds ST_DONE.
// The shared 32x32 mixing multiplier runs twice per word; the single table port is used
// once per word, and a lookup checks the registered read in ST_READ.
// Reset: async, active low; ttl returns to 60 and a clearing pass over all CACHE_ENTRIES
// slots zeroes the table before the first word is accepted.
`include "recent_address_ttl_cache_top_assert.svh"

module recent_address_ttl_cache_top #(
  parameter int unsigned CACHE_ENTRIES = rattc_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic [rattc_pkg::ADDR_W-1:0]  addr_i,
  input  logic [rattc_pkg::TIME_W-1:0]  now_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          seen_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rattc_pkg::TTL_W-1:0]   ttl_seconds_i
);
  import rattc_pkg::*;

  localparam int unsigned IDX_W = $clog2(CACHE_ENTRIES);
  localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(CACHE_ENTRIES - 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CACHE_ENTRIES - 1);

  state_e state_q, state_d;

  logic [TTL_W-1:0]  ttl_q;
  logic [IDX_W-1:0]  clr_cnt_q;
  logic              mode_q;
  logic [ADDR_W-1:0] addr_q;
  logic [TIME_W-1:0] now_q;
  logic              seen_q, seen_d;

  logic              in_accept;
  mix_ctrl_t         mix_ctrl;
  logic [HASH_W-1:0] hash;
  logic [IDX_W-1:0]  slot_idx;

  logic              ram_en, ram_we;
  logic [IDX_W-1:0]  ram_addr;
  logic [SLOT_W-1:0] ram_wdata, ram_rdata;

  logic [ADDR_W-1:0] st_addr;
  logic [TIME_W-1:0] st_time;
  logic [TIME_W:0]   age;
  logic              live, hit;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  rattc_mix u_mix (
    .clk_i  (clk_i),
    .ctrl_i (mix_ctrl),
    .addr_i (addr_i),
    .hash_o (hash)
  );

  rattc_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (CACHE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign slot_idx = hash[IDX_W-1:0] & IDX_MASK;

  // lookup check on the registered slot read
  assign st_addr = ram_rdata[SLOT_W-1:TIME_W];
  assign st_time = ram_rdata[TIME_W-1:0];
  assign age     = {1'b0, now_q} - {1'b0, st_time};
  // negative age means a stored time ahead of now: still recent
  assign live    = age[TIME_W] || (age[TIME_W-1:0] <= {{(TIME_W-TTL_W){1'b0}}, ttl_q});
  assign hit     = (st_addr != '0) && (st_addr == addr_q) && live;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (clr_cnt_q == IDX_LAST) state_d = ST_IDLE;
      ST_IDLE:   if (in_accept) state_d = ST_MIX1;
      ST_MIX1:   state_d = ST_MIX2;
      ST_MIX2:   state_d = ST_ACCESS;
      ST_ACCESS: state_d = (mode_q == MODE_LOOKUP) ? ST_READ : ST_DONE;
      ST_READ:   state_d = ST_DONE;
      ST_DONE:   if (!out_stall_i) state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_stall_o    = 1'b1;
    mix_ctrl.load = 1'b0;
    mix_ctrl.step = 1'b0;
    ram_en        = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = slot_idx;
    ram_wdata     = {addr_q, now_q};
    seen_d        = seen_q;
    unique case (state_q)
      ST_CLEAR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_cnt_q;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        mix_ctrl.load = in_accept;
      end
      ST_MIX1, ST_MIX2: begin
        mix_ctrl.step = 1'b1;
      end
      ST_ACCESS: begin
        ram_en = 1'b1;
        ram_we = (mode_q == MODE_RECORD);
        seen_d = 1'b0;
      end
      ST_READ: begin
        seen_d = hit;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      ttl_q     <= TTL_RESET;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR && clr_cnt_q != IDX_LAST) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        ttl_q <= ttl_seconds_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q <= mode_i;
      addr_q <= addr_i;
      now_q  <= now_i;
    end
    seen_q <= seen_d;
  end

  assign out_valid_o = (state_q == ST_DONE);
  assign seen_o      = seen_q;

  `RATTC_ASSERT(a_record_no_hit,
                out_valid_o && (mode_q == MODE_RECORD) |-> !seen_o,
                "record word reported seen")
  `RATTC_ASSERT(a_clear_full,
                $fell(state_q == ST_CLEAR) |-> $past(clr_cnt_q) == IDX_LAST,
                "clearing pass ended early")
  `RATTC_ASSERT(a_record_writes,
                (state_q == ST_ACCESS) && (mode_q == MODE_RECORD) |-> ram_en && ram_we,
                "record word did not write its slot")
  `RATTC_ASSERT_NEVER(a_ram_busy_idle,
                      ram_en && (state_q == ST_IDLE || state_q == ST_DONE),
                      "table accessed outside a word")

endmodule

/* sim/recent_address_ttl_cache_top_test.sv */
module recent_address_ttl_cache_top_test;
  import rattc_pkg::*;

  localparam int unsigned ENTRIES    = CACHE_ENTRIES_DEF;
  localparam int unsigned IDLE_LIMIT = 4000;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic                mode_i        = 1'b0;
  logic [ADDR_W-1:0]   addr_i        = '0;
  logic [TIME_W-1:0]   now_i         = '0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic                seen_o;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [TTL_W-1:0]    ttl_seconds_i = '0;

  recent_address_ttl_cache_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .addr_i        (addr_i),
    .now_i         (now_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .seen_o        (seen_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .ttl_seconds_i (ttl_seconds_i)
  );

  always #6 clk_i = ~clk_i;

  // shadow copy of the table and the ttl register
  logic [ADDR_W-1:0] model_addr  [ENTRIES];
  logic [TIME_W-1:0] model_stamp [ENTRIES];
  logic [TTL_W-1:0]  model_ttl;
  bit                pending_seen[$];

  int unsigned mismatches    = 0;
  int unsigned words_sent    = 0;
  int unsigned words_checked = 0;
  int unsigned hits          = 0;
  int unsigned ttl_writes    = 0;
  int unsigned idle_cycles   = 0;
  int unsigned stall_run     = 0;
  int unsigned burst_left    = 0;
  bit          want_seen;

  // recently recorded addresses, used to aim lookups at live entries
  logic [ADDR_W-1:0] pool_addr  [16];
  logic [TIME_W-1:0] pool_stamp [16];
  int unsigned       pool_fill  = 0;
  int unsigned       pool_next  = 0;
  logic [TIME_W-1:0] wall_clock;

  function automatic int unsigned slot_index(logic [ADDR_W-1:0] a);
    logic [31:0] x;
    x = {8'd0, a};
    x = (x ^ (x >> 16)) * MIX_MULT;
    x = (x ^ (x >> 16)) * MIX_MULT;
    x = x ^ (x >> 16);
    return x & (ENTRIES - 1);
  endfunction

  function automatic void predict_word(mode_e m, logic [ADDR_W-1:0] a, logic [TIME_W-1:0] t);
    int unsigned       s;
    logic signed [33:0] age;
    logic signed [33:0] limit;
    bit                hit;
    s   = slot_index(a);
    hit = 1'b0;
    if (m == MODE_RECORD) begin
      model_addr[s]  = a;
      model_stamp[s] = t;
    end else begin
      // exact signed age, a stamp in the future counts as live
      age   = {2'b00, t} - {2'b00, model_stamp[s]};
      limit = {18'd0, model_ttl};
      hit   = (model_addr[s] != '0) && (model_addr[s] == a) && (age <= limit);
    end
    pending_seen.push_back(hit);
  endfunction

  task automatic send_word(mode_e m, logic [ADDR_W-1:0] a, logic [TIME_W-1:0] t);
    in_valid_i <= 1'b1;
    mode_i     <= m;
    addr_i     <= a;
    now_i      <= t;
    do @(posedge clk_i); while (in_stall_o);
    predict_word(m, a, t);
    words_sent++;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 10);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_seen.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_ttl(logic [TTL_W-1:0] v);
    wait_drained();
    cfg_valid_i   <= 1'b1;
    ttl_seconds_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    model_ttl   = v;
    cfg_valid_i <= 1'b0;
    ttl_writes++;
    @(posedge clk_i);
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_seen.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word, expected none, actual seen=%0b", $time, seen_o);
      end else begin
        want_seen = pending_seen.pop_front();
        words_checked++;
        if (seen_o) hits++;
        if (seen_o !== want_seen) begin
          mismatches++;
          $display("%0t: seen mismatch, expected %0b, actual %0b", $time, want_seen, seen_o);
        end
      end
    end
    if (stall_run > 0) begin
      stall_run--;
    end else if (!out_stall_i && $urandom_range(0, 3) != 0) begin
      out_stall_i <= 1'b1;
      stall_run = $urandom_range(0, 6);
    end else begin
      out_stall_i <= 1'b0;
      stall_run = $urandom_range(0, 24);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: timeout, no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_cleared_table();
    send_word(MODE_LOOKUP, 24'h000000, 32'd0);
    send_word(MODE_LOOKUP, 24'hFFFFFF, 32'd0);
    send_word(MODE_LOOKUP, 24'h123456, 32'hFFFF_FFFF);
  endtask

  // reset ttl of 60 s
  task automatic test_age_window();
    send_word(MODE_RECORD, 24'h4840D6, 32'd1000);
    send_word(MODE_LOOKUP, 24'h4840D6, 32'd1000);
    send_word(MODE_LOOKUP, 24'h4840D6, 32'd1060);
    send_word(MODE_LOOKUP, 24'h4840D6, 32'd1061);
    send_word(MODE_LOOKUP, 24'h4840D6, 32'd999);
    send_word(MODE_LOOKUP, 24'h4840D6, 32'd0);
  endtask

  task automatic test_time_extremes();
    send_word(MODE_RECORD, 24'hFFFFFF, 32'hFFFF_FFFF);
    send_word(MODE_LOOKUP, 24'hFFFFFF, 32'd0);
    send_word(MODE_RECORD, 24'h000001, 32'd0);
    send_word(MODE_LOOKUP, 24'h000001, 32'hFFFF_FFFF);
    send_word(MODE_LOOKUP, 24'h000001, 32'd60);
  endtask

  task automatic test_zero_and_collision();
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
    a = 24'hABCDEF;
    b = a + 24'd1;
    while (slot_index(b) != slot_index(a)) b++;
    send_word(MODE_RECORD, 24'h000000, 32'd5);
    send_word(MODE_LOOKUP, 24'h000000, 32'd5);
    send_word(MODE_RECORD, a, 32'd100);
    send_word(MODE_LOOKUP, a, 32'd100);
    send_word(MODE_RECORD, b, 32'd100);
    send_word(MODE_LOOKUP, a, 32'd100);
    send_word(MODE_LOOKUP, b, 32'd100);
  endtask

  task automatic test_ttl_extremes();
    set_ttl(16'd0);
    send_word(MODE_RECORD, 24'h800000, 32'd500);
    send_word(MODE_LOOKUP, 24'h800000, 32'd500);
    send_word(MODE_LOOKUP, 24'h800000, 32'd501);
    send_word(MODE_LOOKUP, 24'h800000, 32'd499);
    set_ttl(16'hFFFF);
    send_word(MODE_RECORD, 24'h7FFFFF, 32'd10);
    send_word(MODE_LOOKUP, 24'h7FFFFF, 32'd65545);
    send_word(MODE_LOOKUP, 24'h7FFFFF, 32'd65546);
  endtask

  task automatic random_word();
    int unsigned       r;
    int unsigned       k;
    logic [ADDR_W-1:0] a;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] offset;
    r = $urandom_range(0, 99);
    wall_clock += $urandom_range(0, 40);
    if (r < 35 || pool_fill == 0) begin
      a = ADDR_W'($urandom());
      // sometimes re-record a known address with a fresh stamp
      if (r < 8 && pool_fill != 0) a = pool_addr[$urandom_range(0, pool_fill - 1)];
      t = wall_clock;
      pool_addr[pool_next]  = a;
      pool_stamp[pool_next] = t;
      pool_next = (pool_next + 1) % 16;
      if (pool_fill < 16) pool_fill++;
      send_word(MODE_RECORD, a, t);
    end else if (r < 80) begin
      k = $urandom_range(0, pool_fill - 1);
      case ($urandom_range(0, 4))
        0: begin
          offset = TIME_W'(model_ttl);
        end
        1: begin
          offset = TIME_W'(model_ttl) + 1;
        end
        2: begin
          offset = $urandom_range(0, model_ttl);
        end
        3: begin
          offset = -$urandom_range(1, 100);
        end
        default: begin
          offset = $urandom_range(0, 2 * model_ttl + 2);
        end
      endcase
      send_word(MODE_LOOKUP, pool_addr[k], pool_stamp[k] + offset);
    end else if (r < 92) begin
      a = ($urandom_range(0, 3) == 0) ? '0 : ADDR_W'($urandom());
      t = $urandom();
      send_word(MODE_LOOKUP, a, t);
    end else begin
      a = ADDR_W'($urandom());
      t = $urandom();
      send_word(mode_e'($urandom_range(0, 1)), a, t);
    end
  endtask

  task automatic test_random_traffic();
    logic [TTL_W-1:0] ttl_plan [5];
    ttl_plan[0] = 16'd60;
    ttl_plan[1] = 16'd0;
    ttl_plan[2] = 16'hFFFF;
    ttl_plan[3] = TTL_W'($urandom());
    ttl_plan[4] = TTL_W'($urandom_range(1, 200));
    for (int p = 0; p < 5; p++) begin
      set_ttl(ttl_plan[p]);
      repeat (100) random_word();
    end
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      model_addr[i]  = '0;
      model_stamp[i] = '0;
    end
    model_ttl  = TTL_RESET;
    wall_clock = $urandom();
    burst_left = $urandom_range(0, 10);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_cleared_table();
    test_age_window();
    test_time_extremes();
    test_zero_and_collision();
    test_ttl_extremes();
    test_random_traffic();

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d words, checked %0d results, %0d lookup hits", words_sent, words_checked,
             hits);
    $display("Covered %0d ttl writes incl. 0 and 65535, zero address, collisions, time wrap",
             ttl_writes);
    if (mismatches == 0 && pending_seen.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
